// File: design/adc_temperature_segment_display_assert.svh
// Assertion macros shared by the display driver checkers.
// Depends on nothing; include by bare file name.
`ifndef ADC_TEMPERATURE_SEGMENT_DISPLAY_ASSERT_SVH
`define ADC_TEMPERATURE_SEGMENT_DISPLAY_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define ADC_TSD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication, checked out of reset
`define ADC_TSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// File: design/adc_tsd_pkg.sv
// Shared constants, types and helper functions of the temperature display driver.
// Depends on nothing.
package adc_tsd_pkg;

    localparam int unsigned DIGIT_COUNT = 4;
    localparam int unsigned SAMPLE_W    = 10;
    localparam int unsigned SCALE_W     = 17;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 17;
    localparam int unsigned SEG_W       = 8;
    localparam int unsigned FRAME_W     = SEG_W * DIGIT_COUNT;
    localparam int unsigned POS_W       = $clog2(FRAME_W);
    localparam int unsigned PROD_W      = 29;
    localparam int unsigned MAG_W       = 14;
    localparam int unsigned ROUND_SHIFT = 16;
    localparam int unsigned FIFO_DEPTH  = 2;
    localparam int unsigned FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 1'd1;

    localparam logic [SAMPLE_W-1:0] OFFSET_RESET = 10'd96;
    localparam logic [SCALE_W-1:0]  SCALE_RESET  = 17'd85923;

    localparam logic [PROD_W-1:0] ROUND_HALF  = 29'h0_8000;
    localparam logic [MAG_W-1:0]  MAG_MAX_POS = 14'd9999;
    localparam logic [MAG_W-1:0]  MAG_MAX_NEG = 14'd999;

    // x / 10 == (x * 52429) >> 19 for every x below 43699
    localparam logic [15:0]  RECIP10     = 16'd52429;
    localparam int unsigned  RECIP_SHIFT = 19;

    localparam logic [SEG_W-1:0] SEG_MINUS = 8'hbf;
    localparam logic [POS_W-1:0] LAST_POS  = POS_W'(FRAME_W - 1);

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    // Active-low seven-segment code of a decimal digit
    function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
        logic [SEG_W-1:0] code;
        case (digit)
            4'd0:    code = 8'hc0;
            4'd1:    code = 8'hf9;
            4'd2:    code = 8'ha4;
            4'd3:    code = 8'hb0;
            4'd4:    code = 8'h99;
            4'd5:    code = 8'h92;
            4'd6:    code = 8'h82;
            4'd7:    code = 8'hf8;
            4'd8:    code = 8'h80;
            4'd9:    code = 8'h90;
            default: code = 8'hff;
        endcase
        return code;
    endfunction

    // Quotient by ten through the reciprocal multiply
    function automatic logic [MAG_W-1:0] div10(input logic [MAG_W-1:0] x);
        logic [MAG_W+15:0] prod;
        prod = (MAG_W + 16)'(x) * (MAG_W + 16)'(RECIP10);
        return MAG_W'(prod >> RECIP_SHIFT);
    endfunction

    // Low digit left over after taking the quotient by ten
    function automatic logic [3:0] rem10(input logic [MAG_W-1:0] x,
                                         input logic [MAG_W-1:0] q);
        logic [MAG_W-1:0] diff;
        diff = x - ((q << 3) + (q << 1));
        return diff[3:0];
    endfunction

endpackage

// File: design/adc_tsd_fifo.sv
// Two-entry frame queue between the conversion pipeline and the serializer.
// Depends on adc_tsd_pkg.
module adc_tsd_fifo (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  logic [adc_tsd_pkg::FRAME_W-1:0]    i_data,
    input  logic                               i_pop,
    output logic [adc_tsd_pkg::FRAME_W-1:0]    o_data,
    output adc_tsd_pkg::t_fifo_stat            o_stat
);

    logic [adc_tsd_pkg::FRAME_W-1:0]    r_mem [adc_tsd_pkg::FIFO_DEPTH];
    logic [adc_tsd_pkg::FIFO_PTR_W-1:0] r_wr_ptr;
    logic [adc_tsd_pkg::FIFO_PTR_W-1:0] r_rd_ptr;
    logic [adc_tsd_pkg::FIFO_CNT_W-1:0] r_count;
    logic [adc_tsd_pkg::FIFO_CNT_W-1:0] n_count;
    logic                               do_push;
    logic                               do_pop;

    assign o_stat.full  = (r_count == adc_tsd_pkg::FIFO_CNT_W'(adc_tsd_pkg::FIFO_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd_ptr];

    // Track occupancy
    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // Store frames
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: design/adc_tsd_front.sv
// Front end: holds the configuration, scales a sample and turns it into a segment frame.
// Depends on adc_tsd_pkg.
module adc_tsd_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [adc_tsd_pkg::SAMPLE_W-1:0]     i_adc_sample,
    input  logic                                 i_cfg_we,
    input  logic [adc_tsd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [adc_tsd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  adc_tsd_pkg::t_fifo_stat              i_fifo_stat,
    output logic                                 o_busy,
    output logic                                 o_push,
    output logic [adc_tsd_pkg::FRAME_W-1:0]      o_frame
);

    logic [adc_tsd_pkg::SAMPLE_W-1:0] r_offset;
    logic [adc_tsd_pkg::SCALE_W-1:0]  r_scale;

    // Stage valids
    logic r_s0_v, r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v;

    // Stage payloads
    logic [adc_tsd_pkg::SAMPLE_W-1:0]    r_s0_smp;
    logic signed [adc_tsd_pkg::PROD_W-1:0] r_s1_prod;
    logic [adc_tsd_pkg::MAG_W-1:0]       r_s2_mag;
    logic                                r_s2_neg;
    logic [adc_tsd_pkg::MAG_W-1:0]       r_s3_quot;
    logic [3:0]                          r_s3_d0;
    logic                                r_s3_neg;
    logic [adc_tsd_pkg::MAG_W-1:0]       r_s4_quot;
    logic [3:0]                          r_s4_d0;
    logic [3:0]                          r_s4_d1;
    logic                                r_s4_neg;
    logic [adc_tsd_pkg::FRAME_W-1:0]     r_s5_frame;

    logic                                  advance;
    logic                                  accept;
    logic signed [adc_tsd_pkg::SAMPLE_W:0] diff;
    logic signed [adc_tsd_pkg::SCALE_W:0]  scale_s;
    logic signed [adc_tsd_pkg::PROD_W-1:0] prod;
    logic                                  neg;
    logic [adc_tsd_pkg::PROD_W-1:0]        abs_prod;
    logic [adc_tsd_pkg::PROD_W-1:0]        rounded;
    logic [adc_tsd_pkg::MAG_W-1:0]         mag_raw;
    logic [adc_tsd_pkg::MAG_W-1:0]         mag_sat;
    logic [adc_tsd_pkg::MAG_W-1:0]         q1, q2, q3;
    logic [3:0]                            d2, d3;
    logic [adc_tsd_pkg::SEG_W-1:0]         seg_lead;

    // Hold every stage while the last one waits on a full queue
    assign advance = !(r_s5_v && i_fifo_stat.full);
    assign o_busy  = !advance;
    assign accept  = i_start && advance;
    assign o_push  = r_s5_v && !i_fifo_stat.full;
    assign o_frame = r_s5_frame;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= adc_tsd_pkg::OFFSET_RESET;
            r_scale  <= adc_tsd_pkg::SCALE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                adc_tsd_pkg::REG_OFFSET: r_offset <= i_cfg_data[adc_tsd_pkg::SAMPLE_W-1:0];
                adc_tsd_pkg::REG_SCALE:  r_scale  <= i_cfg_data[adc_tsd_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Offset and scale; widen both operands to the full product width
    assign diff    = $signed({1'b0, r_s0_smp}) - $signed({1'b0, r_offset});
    assign scale_s = $signed({1'b0, r_scale});
    assign prod    = adc_tsd_pkg::PROD_W'(diff) * adc_tsd_pkg::PROD_W'(scale_s);

    // Sign, round half up, saturate
    assign neg      = r_s1_prod[adc_tsd_pkg::PROD_W-1];
    assign abs_prod = neg ? adc_tsd_pkg::PROD_W'(-r_s1_prod)
                          : adc_tsd_pkg::PROD_W'(r_s1_prod);
    assign rounded  = abs_prod + adc_tsd_pkg::ROUND_HALF;
    assign mag_raw  = adc_tsd_pkg::MAG_W'(rounded >> adc_tsd_pkg::ROUND_SHIFT);

    always_comb begin
        mag_sat = mag_raw;
        if (neg) begin
            if (mag_raw > adc_tsd_pkg::MAG_MAX_NEG) begin
                mag_sat = adc_tsd_pkg::MAG_MAX_NEG;
            end
        end else if (mag_raw > adc_tsd_pkg::MAG_MAX_POS) begin
            mag_sat = adc_tsd_pkg::MAG_MAX_POS;
        end
    end

    // Peel one decimal digit per stage; the last stage takes the top two
    assign q1 = adc_tsd_pkg::div10(r_s2_mag);
    assign q2 = adc_tsd_pkg::div10(r_s3_quot);
    assign q3 = adc_tsd_pkg::div10(r_s4_quot);
    assign d2 = adc_tsd_pkg::rem10(r_s4_quot, q3);
    assign d3 = q3[3:0];

    // Leading symbol is the minus sign for a negative value
    assign seg_lead = r_s4_neg ? adc_tsd_pkg::SEG_MINUS : adc_tsd_pkg::seg_code(d3);

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
        end else if (advance) begin
            r_s0_v <= accept;
            r_s1_v <= r_s0_v;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
        end
    end

    // Stage payloads; units byte goes out first
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s0_smp   <= i_adc_sample;
            r_s1_prod  <= prod;
            r_s2_mag   <= mag_sat;
            r_s2_neg   <= neg;
            r_s3_quot  <= q1;
            r_s3_d0    <= adc_tsd_pkg::rem10(r_s2_mag, q1);
            r_s3_neg   <= r_s2_neg;
            r_s4_quot  <= q2;
            r_s4_d0    <= r_s3_d0;
            r_s4_d1    <= adc_tsd_pkg::rem10(r_s3_quot, q2);
            r_s4_neg   <= r_s3_neg;
            r_s5_frame <= {adc_tsd_pkg::seg_code(r_s4_d0), adc_tsd_pkg::seg_code(r_s4_d1),
                           adc_tsd_pkg::seg_code(d2), seg_lead};
        end
    end

endmodule

// File: design/adc_tsd_back.sv
// Back end: shifts queued segment frames out one bit per cycle, MSB of the frame first.
// Depends on adc_tsd_pkg.
module adc_tsd_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  adc_tsd_pkg::t_fifo_stat          i_fifo_stat,
    input  logic [adc_tsd_pkg::FRAME_W-1:0]  i_frame,
    output logic                             o_pop,
    output logic                             o_strobe,
    output logic                             o_serial_bit,
    output logic [adc_tsd_pkg::POS_W-1:0]    o_bit_position,
    output logic                             o_frame_last
);

    logic                            r_active;
    logic [adc_tsd_pkg::POS_W-1:0]   r_pos;
    logic [adc_tsd_pkg::FRAME_W-1:0] r_shift;
    logic                            at_last;

    assign at_last = (r_pos == adc_tsd_pkg::LAST_POS);

    // Load the next frame right after the last bit of the current one, or whenever idle
    assign o_pop = (!r_active || at_last) && !i_fifo_stat.empty;

    assign o_strobe       = r_active;
    assign o_serial_bit   = r_shift[adc_tsd_pkg::FRAME_W-1];
    assign o_bit_position = r_pos;
    assign o_frame_last   = r_active && at_last;

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pos    <= '0;
        end else if (o_pop) begin
            r_active <= 1'b1;
            r_pos    <= '0;
        end else if (r_active) begin
            if (at_last) begin
                r_active <= 1'b0;
            end
            r_pos <= r_pos + 1'b1;
        end
    end

    // Shift register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_shift <= i_frame;
        end else if (r_active) begin
            r_shift <= {r_shift[adc_tsd_pkg::FRAME_W-2:0], 1'b0};
        end
    end

endmodule

// File: design/adc_temperature_segment_display.sv
// Top level of the serial seven-segment temperature display driver.
// Depends on adc_tsd_pkg, adc_tsd_front, adc_tsd_fifo and adc_tsd_back.
//
// Usage:
//   Raise i_start with i_adc_sample; the sample is taken at a clock edge where
//   i_start is high and o_busy is low. Each sample yields a 32-bit frame of
//   active-low segment bytes (units digit first, each byte MSB first), sent as
//   32 results on consecutive cycles marked by o_result_strobe, with
//   o_bit_position counting 0..31 and o_frame_last high on bit 31.
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
//   (0 offset counts, 1 Q16 tenths scale) at the clock edge; write only idle.
// Path: an accepted sample passes six pipeline stages and the queue before its
//   bit 0 reaches the ports through the bit shifter.
// Throughput: the sustained sample rate is set by the bit shifter, which sends
//   each frame whole; the pipeline and a two-frame queue take samples one per
//   cycle until full, then o_busy holds the pipeline until the queue has room.
// Reset: i_rst_n low at an edge empties pipeline and queue and restores the
//   register reset values. The receiver cannot stall; bits are never held.
module adc_temperature_segment_display (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  logic [adc_tsd_pkg::SAMPLE_W-1:0]     i_adc_sample,
    input  logic                                 i_cfg_we,
    input  logic [adc_tsd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [adc_tsd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                                 o_result_strobe,
    output logic                                 o_serial_bit,
    output logic [adc_tsd_pkg::POS_W-1:0]        o_bit_position,
    output logic                                 o_frame_last
);

    adc_tsd_pkg::t_fifo_stat          fifo_stat;
    logic                             push;
    logic                             pop;
    logic [adc_tsd_pkg::FRAME_W-1:0]  front_frame;
    logic [adc_tsd_pkg::FRAME_W-1:0]  queue_frame;

    // Scale and encode
    adc_tsd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_adc_sample (i_adc_sample),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_fifo_stat  (fifo_stat),
        .o_busy       (o_busy),
        .o_push       (push),
        .o_frame      (front_frame)
    );

    // Buffer frames
    adc_tsd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_frame),
        .i_pop   (pop),
        .o_data  (queue_frame),
        .o_stat  (fifo_stat)
    );

    // Serialize
    adc_tsd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fifo_stat    (fifo_stat),
        .i_frame        (queue_frame),
        .o_pop          (pop),
        .o_strobe       (o_result_strobe),
        .o_serial_bit   (o_serial_bit),
        .o_bit_position (o_bit_position),
        .o_frame_last   (o_frame_last)
    );

endmodule

// File: design/adc_tsd_chk.sv
// Port-level checker for the temperature display driver, bound to the top level.
// Depends on adc_tsd_pkg and adc_temperature_segment_display_assert.svh.
`include "adc_temperature_segment_display_assert.svh"

module adc_tsd_chk (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_start,
    input logic                                 o_busy,
    input logic [adc_tsd_pkg::SAMPLE_W-1:0]     i_adc_sample,
    input logic                                 i_cfg_we,
    input logic [adc_tsd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input logic [adc_tsd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input logic                                 o_result_strobe,
    input logic                                 o_serial_bit,
    input logic [adc_tsd_pkg::POS_W-1:0]        o_bit_position,
    input logic                                 o_frame_last
);

    // A frame starts at bit zero
    `ADC_TSD_ASSERT_IMPLY(a_frame_starts_at_zero, i_clk, i_rst_n, $rose(o_result_strobe), o_bit_position == '0)

    // Bits within a frame come on consecutive cycles in order
    `ADC_TSD_ASSERT_NEXT(a_bits_consecutive, i_clk, i_rst_n, o_result_strobe && !o_frame_last, o_result_strobe && (o_bit_position == $past(o_bit_position) + 1'b1))

    // The last flag marks exactly bit 31 of a strobed result
    `ADC_TSD_ASSERT_IMPLY(a_last_at_end, i_clk, i_rst_n, o_result_strobe, o_frame_last == (o_bit_position == adc_tsd_pkg::LAST_POS))

    // Nothing is emitted and o_busy is low in the first cycle after reset
    `ADC_TSD_ASSERT_IMPLY(a_quiet_after_reset, i_clk, i_rst_n, $past(!i_rst_n), !o_result_strobe && !o_busy)

endmodule

bind adc_temperature_segment_display adc_tsd_chk u_adc_tsd_chk (.*);

// File: tb/adc_temperature_segment_display_tb.sv
// Self-checking testbench for the serial seven-segment temperature display driver.
// Depends on adc_tsd_pkg and adc_temperature_segment_display; drives samples and
// register writes, predicts every serial bit and checks each one as it leaves.
module adc_temperature_segment_display_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // One serial bit of a display frame
    typedef struct {
        logic                          seg_bit;
        logic [adc_tsd_pkg::POS_W-1:0] pos;
        logic                          last;
    } t_seg_bit;

    // Active-low segment codes of the digits 0..9
    localparam logic [adc_tsd_pkg::SEG_W-1:0] DIGIT_SEGS [10] = '{
        8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8, 8'h80, 8'h90
    };
    localparam int RAND_PHASES      = 6;
    localparam int SAMPLES_PER_PHASE = 31;
    localparam int DRAIN_CYCLES     = 12;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_start = 1'b0;
    logic                               o_busy;
    logic [adc_tsd_pkg::SAMPLE_W-1:0]   i_adc_sample = '0;
    logic                               i_cfg_we = 1'b0;
    logic [adc_tsd_pkg::CFG_IDX_W-1:0]  i_cfg_idx = adc_tsd_pkg::REG_OFFSET;
    logic [adc_tsd_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                               o_result_strobe;
    logic                               o_serial_bit;
    logic [adc_tsd_pkg::POS_W-1:0]      o_bit_position;
    logic                               o_frame_last;

    logic [adc_tsd_pkg::SAMPLE_W-1:0] pending_samples [$];
    t_seg_bit                         bits_due [$];
    t_seg_bit                         bit_want;
    logic [adc_tsd_pkg::SAMPLE_W-1:0] cur_offset = adc_tsd_pkg::OFFSET_RESET;
    logic [adc_tsd_pkg::SCALE_W-1:0]  cur_scale = adc_tsd_pkg::SCALE_RESET;
    int                               samples_taken = 0;
    int                               mismatch_count = 0;

    adc_temperature_segment_display dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_adc_sample    (i_adc_sample),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_result_strobe (o_result_strobe),
        .o_serial_bit    (o_serial_bit),
        .o_bit_position  (o_bit_position),
        .o_frame_last    (o_frame_last)
    );

    always #5 i_clk = ~i_clk;

    // Convert a sample to its 32 display bits and queue them for checking
    function automatic void queue_display_bits(input logic [adc_tsd_pkg::SAMPLE_W-1:0] sample);
        longint                        diff;
        longint                        prod;
        longint                        mag;
        bit                            neg;
        logic [adc_tsd_pkg::SEG_W-1:0] sym [adc_tsd_pkg::DIGIT_COUNT];
        t_seg_bit                      sb;
        diff = longint'(sample) - longint'(cur_offset);
        prod = diff * longint'(cur_scale);
        neg  = prod < 0;
        mag  = neg ? -prod : prod;
        mag  = (mag + 64'h8000) >> adc_tsd_pkg::ROUND_SHIFT;
        if (neg && mag > 999)
            mag = 999;
        else if (!neg && mag > 9999)
            mag = 9999;
        for (int d = adc_tsd_pkg::DIGIT_COUNT - 1; d >= 0; d--) begin
            sym[d] = DIGIT_SEGS[mag % 10];
            mag = mag / 10;
        end
        if (neg)
            sym[0] = adc_tsd_pkg::SEG_MINUS;
        // Units digit leaves first, each byte MSB first
        for (int p = 0; p < adc_tsd_pkg::FRAME_W; p++) begin
            sb.seg_bit = sym[adc_tsd_pkg::DIGIT_COUNT - 1 - p / adc_tsd_pkg::SEG_W]
                            [adc_tsd_pkg::SEG_W - 1 - p % adc_tsd_pkg::SEG_W];
            sb.pos     = adc_tsd_pkg::POS_W'(p);
            sb.last    = (p == adc_tsd_pkg::FRAME_W - 1);
            bits_due.push_back(sb);
        end
    endfunction

    // Driver: present queued samples, idle at random outside the steady stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                queue_display_bits(i_adc_sample);
                samples_taken++;
            end
            if (!i_start || !o_busy) begin
                if (pending_samples.size() != 0 &&
                    ((samples_taken >= 100 && samples_taken < 150) ||
                     $urandom_range(99) >= 34)) begin
                    i_start      <= 1'b1;
                    i_adc_sample <= pending_samples.pop_front();
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // Monitor: check every strobed bit against the oldest expected one
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe) begin
            if (bits_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected bit: serial_bit %0b position %0d last %0b",
                             o_serial_bit, o_bit_position, o_frame_last);
            end else begin
                bit_want = bits_due.pop_front();
                if (o_serial_bit !== bit_want.seg_bit || o_bit_position !== bit_want.pos ||
                    o_frame_last !== bit_want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("bit mismatch: expected %0b/%0d/%0b, got %0b/%0d/%0b",
                                 bit_want.seg_bit, bit_want.pos, bit_want.last,
                                 o_serial_bit, o_bit_position, o_frame_last);
                end
            end
        end
    end

    // Wait until every sample is taken and every bit has left, then settle
    task automatic wait_drained();
        while (pending_samples.size() != 0 || i_start || bits_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers while the block is idle
    task automatic set_calibration(input logic [adc_tsd_pkg::SAMPLE_W-1:0] offset,
                                   input logic [adc_tsd_pkg::SCALE_W-1:0] scale);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= adc_tsd_pkg::REG_OFFSET;
        i_cfg_data <= adc_tsd_pkg::CFG_DATA_W'(offset);
        @(posedge i_clk);
        i_cfg_idx  <= adc_tsd_pkg::REG_SCALE;
        i_cfg_data <= adc_tsd_pkg::CFG_DATA_W'(scale);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_offset = offset;
        cur_scale  = scale;
    endtask

    // Sample near the zero point three times in ten on average, else anywhere
    function automatic logic [adc_tsd_pkg::SAMPLE_W-1:0] pick_sample();
        int s;
        if ($urandom_range(9) < 3) begin
            s = int'(cur_offset) + int'($urandom_range(20)) - 10;
            if (s < 0)
                s = 0;
            if (s > 1023)
                s = 1023;
        end else begin
            s = int'($urandom_range(1023));
        end
        return adc_tsd_pkg::SAMPLE_W'(s);
    endfunction

    // Stimulus: directed frames, then random phases over several calibrations
    initial begin
        logic [adc_tsd_pkg::SAMPLE_W-1:0] offs;
        logic [adc_tsd_pkg::SCALE_W-1:0]  scl;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset calibration: extremes, zero point and alternating bits
        pending_samples = '{10'd0, 10'd1023, 10'd96, 10'd95, 10'd97,
                            10'h155, 10'h2aa, 10'd512, 10'd511};
        // Largest scale from zero: widest positive readings
        set_calibration(10'd0, 17'h1ffff);
        pending_samples = '{10'd0, 10'd1023, 10'd1, 10'd500};
        // Largest scale below the zero point: negative saturation at minus 999
        set_calibration(10'd1023, 17'h1ffff);
        pending_samples = '{10'd0, 10'd1023, 10'd1022, 10'd512};
        // Zero scale shows all zeros on either side
        set_calibration(10'd512, 17'd0);
        pending_samples = '{10'd0, 10'd1023};
        // Half-tenth steps: rounding half up away from zero
        set_calibration(10'd512, 17'h08000);
        pending_samples = '{10'd513, 10'd511, 10'd515, 10'd509};
        // Tiny negative products round to a signed zero
        set_calibration(10'd512, 17'd1);
        pending_samples = '{10'd511, 10'd0, 10'd1023};

        // Random phases, extremes of the calibration first
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: begin
                    offs = adc_tsd_pkg::OFFSET_RESET;
                    scl  = adc_tsd_pkg::SCALE_RESET;
                end
                1: begin
                    offs = 10'd0;
                    scl  = 17'h1ffff;
                end
                2: begin
                    offs = 10'd1023;
                    scl  = 17'h1ffff;
                end
                3: begin
                    offs = adc_tsd_pkg::SAMPLE_W'($urandom_range(1023));
                    scl  = adc_tsd_pkg::SCALE_W'($urandom_range(4095));
                end
                default: begin
                    offs = adc_tsd_pkg::SAMPLE_W'($urandom_range(1023));
                    scl  = adc_tsd_pkg::SCALE_W'($urandom_range(131071));
                end
            endcase
            set_calibration(offs, scl);
            for (int k = 0; k < SAMPLES_PER_PHASE; k++)
                pending_samples.push_back(pick_sample());
        end

        wait_drained();
        if (mismatch_count == 0 && bits_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Hang guard
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/adc_tsd_pkg.sv
design/adc_tsd_fifo.sv
design/adc_tsd_front.sv
design/adc_tsd_back.sv
design/adc_temperature_segment_display.sv
design/adc_tsd_chk.sv
tb/adc_temperature_segment_display_tb.sv
